// ===== sv/lsi_pkg.sv =====
// ---------------------------------------------------------------------------
// lsi_pkg
// Shared constants, register codes and lane result type for the lattice
// site index block.
// ---------------------------------------------------------------------------
package lsi_pkg;

  // default sizes handed to the top level
  localparam int unsigned DIMS_DEF       = 4;
  localparam int unsigned COORD_BITS_DEF = 16;
  localparam int unsigned INDEX_BITS_DEF = 32;

  // fixed register field sizes
  localparam int unsigned FIELD_BITS    = 16;
  localparam int unsigned DIV_BITS      = 4;
  localparam int unsigned CFG_BITS      = 64;
  localparam int unsigned CNT_BITS      = 9;
  localparam int unsigned EVEN_BITS     = 32;
  localparam int unsigned DIR_BITS      = 2;
  localparam int unsigned CFG_ADDR_BITS = 3;

  // register reset values
  localparam logic [CFG_BITS-1:0]   ORIGIN_RST = 64'd0;
  localparam logic [CFG_BITS-1:0]   EXTENT_RST = 64'd2251834173947912;
  localparam logic [15:0]           DIVS_RST   = 16'd4369;
  localparam logic [DIR_BITS-1:0]   MDIR_RST   = 2'd0;
  localparam logic [CNT_BITS-1:0]   COUNT_RST  = 9'd1;
  localparam logic [EVEN_BITS-1:0]  EVEN_RST   = 32'd2048;
  localparam logic                  SPLIT_RST  = 1'b1;

  // configuration register indexes
  typedef enum logic [CFG_ADDR_BITS-1:0] {
    REG_ORIGIN = 3'd0,
    REG_EXTENT = 3'd1,
    REG_DIVS   = 3'd2,
    REG_MDIR   = 3'd3,
    REG_COUNT  = 3'd4,
    REG_EVEN   = 3'd5,
    REG_SPLIT  = 3'd6
  } cfg_reg_e;

  // what one lane hands to the merging stage
  typedef struct packed {
    logic                  off_node;
    logic [FIELD_BITS-1:0] quot;
    logic [FIELD_BITS-1:0] rem;
    logic [FIELD_BITS-1:0] sub;
  } lane_res_t;

  // a zero division count acts as one
  function automatic logic [DIV_BITS-1:0] div_fix(input logic [DIV_BITS-1:0] v);
    return (v == '0) ? DIV_BITS'(1) : v;
  endfunction

endpackage

// ===== sv/lsi_div_pipe.sv =====
// ---------------------------------------------------------------------------
// lsi_div_pipe
// Pipelined restoring divider, one quotient bit per stage, with a side
// payload that travels alongside.
// ---------------------------------------------------------------------------
module lsi_div_pipe #(
  parameter int unsigned NUM_BITS  = 16,
  parameter int unsigned DEN_BITS  = 16,
  parameter int unsigned SIDE_BITS = 1
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [NUM_BITS-1:0]  num_i,
  input  logic [DEN_BITS-1:0]  den_i,
  input  logic [SIDE_BITS-1:0] side_i,
  output logic [NUM_BITS-1:0]  quot_o,
  output logic [DEN_BITS-1:0]  rem_o,
  output logic [SIDE_BITS-1:0] side_o
);

  logic [NUM_BITS-1:0]  num_q  [NUM_BITS];
  logic [NUM_BITS-1:0]  quot_q [NUM_BITS];
  logic [DEN_BITS-1:0]  den_q  [NUM_BITS];
  logic [DEN_BITS-1:0]  rem_q  [NUM_BITS];
  logic [SIDE_BITS-1:0] side_q [NUM_BITS];

  logic [NUM_BITS-1:0]  num_p  [NUM_BITS];
  logic [NUM_BITS-1:0]  quot_p [NUM_BITS];
  logic [DEN_BITS-1:0]  den_p  [NUM_BITS];
  logic [DEN_BITS-1:0]  rem_p  [NUM_BITS];
  logic [SIDE_BITS-1:0] side_p [NUM_BITS];
  logic [NUM_BITS-1:0]  quot_d [NUM_BITS];
  logic [DEN_BITS-1:0]  rem_d  [NUM_BITS];
  logic [DEN_BITS:0]    trial  [NUM_BITS];

  // one trial subtraction per stage, msb of the dividend first
  always_comb begin
    for (int i = 0; i < NUM_BITS; i++) begin
      if (i == 0) begin
        num_p[i]  = num_i;
        den_p[i]  = den_i;
        rem_p[i]  = '0;
        quot_p[i] = '0;
        side_p[i] = side_i;
      end else begin
        num_p[i]  = num_q[i-1];
        den_p[i]  = den_q[i-1];
        rem_p[i]  = rem_q[i-1];
        quot_p[i] = quot_q[i-1];
        side_p[i] = side_q[i-1];
      end
      trial[i] = {rem_p[i], num_p[i][NUM_BITS-1-i]};
      if (trial[i] >= {1'b0, den_p[i]}) begin
        rem_d[i]  = DEN_BITS'(trial[i] - {1'b0, den_p[i]});
        quot_d[i] = {quot_p[i][NUM_BITS-2:0], 1'b1};
      end else begin
        rem_d[i]  = trial[i][DEN_BITS-1:0];
        quot_d[i] = {quot_p[i][NUM_BITS-2:0], 1'b0};
      end
    end
  end

  // stage registers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < NUM_BITS; i++) begin
        num_q[i]  <= num_p[i];
        den_q[i]  <= den_p[i];
        side_q[i] <= side_p[i];
        rem_q[i]  <= rem_d[i];
        quot_q[i] <= quot_d[i];
      end
    end
  end

  assign quot_o = quot_q[NUM_BITS-1];
  assign rem_o  = rem_q[NUM_BITS-1];
  assign side_o = side_q[NUM_BITS-1];

endmodule

// ===== sv/lsi_lane.sv =====
// ---------------------------------------------------------------------------
// lsi_lane
// One dimension: box check, subnode size and the split of the offset into
// subnode label and in-subnode offset.
// ---------------------------------------------------------------------------
module lsi_lane import lsi_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [COORD_BITS-1:0] coord_i,
  input  logic [FIELD_BITS-1:0] origin_i,
  input  logic [FIELD_BITS-1:0] extent_i,
  input  logic [DIV_BITS-1:0]   divs_i,
  output lane_res_t             res_o
);

  logic [FIELD_BITS:0]   diff;
  logic [FIELD_BITS-1:0] off_q;
  logic                  out_q;
  logic [FIELD_BITS-1:0] sub_raw;
  logic [FIELD_BITS:0]   side1;
  logic [FIELD_BITS-1:0] sub_fix;
  logic [FIELD_BITS-1:0] quot;
  logic [FIELD_BITS-1:0] rem;
  logic [FIELD_BITS:0]   side2;

  // offset into the box and the range check
  assign diff = {1'b0, FIELD_BITS'(coord_i)} - {1'b0, origin_i};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      off_q <= diff[FIELD_BITS-1:0];
      out_q <= diff[FIELD_BITS] || (diff[FIELD_BITS-1:0] >= extent_i);
    end
  end

  // subnode size = extent / divisions
  lsi_div_pipe #(
    .NUM_BITS (FIELD_BITS),
    .DEN_BITS (DIV_BITS),
    .SIDE_BITS(FIELD_BITS + 1)
  ) u_sub_div (
    .clk_i (clk_i),
    .en_i  (en_i),
    .num_i (extent_i),
    .den_i (div_fix(divs_i)),
    .side_i({out_q, off_q}),
    .quot_o(sub_raw),
    .rem_o (),
    .side_o(side1)
  );

  assign sub_fix = (sub_raw == '0) ? FIELD_BITS'(1) : sub_raw;

  // label and in-subnode offset
  lsi_div_pipe #(
    .NUM_BITS (FIELD_BITS),
    .DEN_BITS (FIELD_BITS),
    .SIDE_BITS(FIELD_BITS + 1)
  ) u_off_div (
    .clk_i (clk_i),
    .en_i  (en_i),
    .num_i (side1[FIELD_BITS-1:0]),
    .den_i (sub_fix),
    .side_i({side1[FIELD_BITS], sub_fix}),
    .quot_o(quot),
    .rem_o (rem),
    .side_o(side2)
  );

  assign res_o.off_node = side2[FIELD_BITS];
  assign res_o.sub      = side2[FIELD_BITS-1:0];
  assign res_o.quot     = quot;
  assign res_o.rem      = rem;

endmodule

// ===== sv/lsi_merge.sv =====
// ---------------------------------------------------------------------------
// lsi_merge
// Combines the lane results mixed-radix from the highest dimension down,
// applies the even/odd split and forms the final slot.
// ---------------------------------------------------------------------------
module lsi_merge import lsi_pkg::*; #(
  parameter int unsigned DIMS       = DIMS_DEF,
  parameter int unsigned INDEX_BITS = INDEX_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  lane_res_t                lanes_i [DIMS],
  input  logic [INDEX_BITS-1:0]    even_quot_i,
  input  logic                     odd_i,
  input  logic [DIMS*DIV_BITS-1:0] divs_i,
  input  logic [DIR_BITS-1:0]      merged_dir_i,
  input  logic                     split_i,
  input  logic [CNT_BITS-1:0]      count_i,
  output logic [INDEX_BITS-1:0]    slot_o,
  output logic                     off_node_o
);

  localparam int unsigned LW = INDEX_BITS + DIV_BITS;
  localparam int unsigned IW = INDEX_BITS + FIELD_BITS;
  localparam int unsigned CW = INDEX_BITS + CNT_BITS;

  lane_res_t             lane_q  [DIMS+1][DIMS];
  logic [INDEX_BITS-1:0] label_q [DIMS+1];
  logic [INDEX_BITS-1:0] idx_q   [DIMS+1];
  logic [INDEX_BITS-1:0] evq_q   [DIMS+1];
  logic                  odd_q   [DIMS+1];
  logic                  off_q   [DIMS+1];
  logic [INDEX_BITS-1:0] idxp_q, labp_q, slot_q;
  logic                  offp_q, offn_q;

  logic                  merged_ok, off_any;
  logic [FIELD_BITS-1:0] qm;
  logic [DIV_BITS-1:0]   dm, dv;
  logic [INDEX_BITS-1:0] label0, half, idxp;
  logic [LW-1:0]         mul_l;
  logic [IW-1:0]         mul_i;
  logic [CW-1:0]         mul_c;
  logic [INDEX_BITS-1:0] label_d [DIMS];
  logic [INDEX_BITS-1:0] idx_d   [DIMS];

  // interleaved label of the merged direction
  always_comb begin
    merged_ok = int'(merged_dir_i) < DIMS;
    qm        = '0;
    dm        = '0;
    off_any   = 1'b0;
    for (int d = 0; d < DIMS; d++) begin
      off_any = off_any | lanes_i[d].off_node;
      if (int'(merged_dir_i) == d) begin
        qm = lanes_i[d].quot;
        dm = div_fix(divs_i[d*DIV_BITS +: DIV_BITS]);
      end
    end
    label0 = merged_ok ? (INDEX_BITS'(qm >> 1) + (qm[0] ? INDEX_BITS'(dm >> 1) : '0)) : '0;
  end

  // one dimension per stage, highest first
  always_comb begin
    mul_l = '0;
    mul_i = '0;
    dv    = '0;
    for (int k = 0; k < DIMS; k++) begin
      dv    = div_fix(divs_i[(DIMS-1-k)*DIV_BITS +: DIV_BITS]);
      mul_l = LW'(label_q[k]) * LW'(dv);
      mul_i = IW'(idx_q[k]) * IW'(lane_q[k][DIMS-1-k].sub);
      if (merged_ok && (int'(merged_dir_i) == DIMS - 1 - k)) begin
        label_d[k] = label_q[k];
      end else begin
        label_d[k] = INDEX_BITS'(mul_l) + INDEX_BITS'(lane_q[k][DIMS-1-k].quot);
      end
      idx_d[k] = INDEX_BITS'(mul_i) + INDEX_BITS'(lane_q[k][DIMS-1-k].rem);
    end
  end

  // even sites first, then odd
  always_comb begin
    half = idx_q[DIMS] >> 1;
    if (!split_i) begin
      idxp = idx_q[DIMS];
    end else if (odd_q[DIMS]) begin
      idxp = half + evq_q[DIMS];
    end else begin
      idxp = half;
    end
    mul_c = CW'(count_i) * CW'(idxp_q);
  end

  // stage registers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q[0]  <= lanes_i;
      label_q[0] <= label0;
      idx_q[0]   <= '0;
      evq_q[0]   <= even_quot_i;
      odd_q[0]   <= odd_i;
      off_q[0]   <= off_any;
      for (int k = 0; k < DIMS; k++) begin
        lane_q[k+1]  <= lane_q[k];
        label_q[k+1] <= label_d[k];
        idx_q[k+1]   <= idx_d[k];
        evq_q[k+1]   <= evq_q[k];
        odd_q[k+1]   <= odd_q[k];
        off_q[k+1]   <= off_q[k];
      end
      idxp_q <= idxp;
      labp_q <= label_q[DIMS];
      offp_q <= off_q[DIMS];
      slot_q <= offp_q ? '0 : (labp_q + INDEX_BITS'(mul_c));
      offn_q <= offp_q;
    end
  end

  assign slot_o     = slot_q;
  assign off_node_o = offn_q;

endmodule

// ===== sv/lattice_site_index.sv =====
// ---------------------------------------------------------------------------
// lattice_site_index
// Maps a global lattice coordinate to its storage slot in this node's box.
// ---------------------------------------------------------------------------
// Usage:
//   The input stream carries one coordinate per transfer, dimension 0 in the
//   lowest bits of s_axis_tdata. The output stream returns one transfer per
//   coordinate: the slot in m_axis_tdata and the off-node flag in
//   m_axis_tuser; the slot reads 0 when the site lies outside the box.
//   Configuration is written through cfg_we_i / cfg_addr_i / cfg_wdata_i
//   while the stream is empty.
//   Each lane holds two bit-per-stage divider pipelines that produce the
//   subnode size and then the label and in-subnode offset. One coordinate
//   is taken every cycle while the receiver does not stall; all lanes and
//   the merging stages run in parallel.
//   When the receiver stalls the whole pipeline holds and s_axis_tready
//   drops; transfers resume without loss when m_axis_tready returns.
//   Reset empties the pipeline and restores the default box: origin 0,
//   extent 8 in every dimension, no subnode split, parity split on.
// ---------------------------------------------------------------------------
module lattice_site_index import lsi_pkg::*; #(
  parameter int unsigned DIMS       = DIMS_DEF,
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  parameter int unsigned INDEX_BITS = INDEX_BITS_DEF
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  // coord_x, coord_y, coord_z, coord_t from the lowest bit up
  input  logic [((DIMS*COORD_BITS+7)/8)*8-1:0]     s_axis_tdata,
  input  logic                                     s_axis_tvalid,
  output logic                                     s_axis_tready,
  // site_slot
  output logic [((INDEX_BITS+7)/8)*8-1:0]          m_axis_tdata,
  // off_node
  output logic                                     m_axis_tuser,
  output logic                                     m_axis_tvalid,
  input  logic                                     m_axis_tready,
  input  logic                                     cfg_we_i,
  input  logic [CFG_ADDR_BITS-1:0]                 cfg_addr_i,
  input  logic [CFG_BITS-1:0]                      cfg_wdata_i
);

  localparam int unsigned LAT     = 2 * FIELD_BITS + DIMS + 4;
  localparam int unsigned OUT_PAD = ((INDEX_BITS + 7) / 8) * 8 - INDEX_BITS;

  logic [CFG_BITS-1:0]   origin_q, extent_q;
  logic [15:0]           divs_q;
  logic [DIR_BITS-1:0]   mdir_q;
  logic [CNT_BITS-1:0]   count_q, count_fix;
  logic [EVEN_BITS-1:0]  even_q, even_quot;
  logic                  split_q;
  logic [LAT-1:0]        vld_q;
  logic                  adv;
  logic                  par_d, par_q, odd;
  lane_res_t             lanes [DIMS];
  logic [INDEX_BITS-1:0] slot;
  logic                  off_node;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_q <= ORIGIN_RST;
      extent_q <= EXTENT_RST;
      divs_q   <= DIVS_RST;
      mdir_q   <= MDIR_RST;
      count_q  <= COUNT_RST;
      even_q   <= EVEN_RST;
      split_q  <= SPLIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        REG_ORIGIN: origin_q <= cfg_wdata_i;
        REG_EXTENT: extent_q <= cfg_wdata_i;
        REG_DIVS:   divs_q   <= cfg_wdata_i[15:0];
        REG_MDIR:   mdir_q   <= cfg_wdata_i[DIR_BITS-1:0];
        REG_COUNT:  count_q  <= cfg_wdata_i[CNT_BITS-1:0];
        REG_EVEN:   even_q   <= cfg_wdata_i[EVEN_BITS-1:0];
        REG_SPLIT:  split_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign count_fix = (count_q == '0) ? CNT_BITS'(1) : count_q;

  // pipeline advances unless a finished result is held
  assign adv           = !vld_q[LAT-1] || m_axis_tready;
  assign s_axis_tready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
    end
  end

  // parity of the coordinate sum
  always_comb begin
    par_d = 1'b0;
    for (int d = 0; d < DIMS; d++) begin
      par_d = par_d ^ s_axis_tdata[d*COORD_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      par_q <= par_d;
    end
  end

  // even-site share per subnode, aligned with the lanes
  lsi_div_pipe #(
    .NUM_BITS (EVEN_BITS),
    .DEN_BITS (CNT_BITS),
    .SIDE_BITS(1)
  ) u_even_div (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (even_q),
    .den_i (count_fix),
    .side_i(par_q),
    .quot_o(even_quot),
    .rem_o (),
    .side_o(odd)
  );

  // one lane per dimension
  for (genvar d = 0; d < DIMS; d++) begin : g_lane
    lsi_lane #(
      .COORD_BITS(COORD_BITS)
    ) u_lane (
      .clk_i   (clk_i),
      .en_i    (adv),
      .coord_i (s_axis_tdata[d*COORD_BITS +: COORD_BITS]),
      .origin_i(origin_q[d*FIELD_BITS +: FIELD_BITS]),
      .extent_i(extent_q[d*FIELD_BITS +: FIELD_BITS]),
      .divs_i  (divs_q[d*DIV_BITS +: DIV_BITS]),
      .res_o   (lanes[d])
    );
  end

  // merging stages and output register
  lsi_merge #(
    .DIMS      (DIMS),
    .INDEX_BITS(INDEX_BITS)
  ) u_merge (
    .clk_i       (clk_i),
    .en_i        (adv),
    .lanes_i     (lanes),
    .even_quot_i (INDEX_BITS'(even_quot)),
    .odd_i       (odd),
    .divs_i      (divs_q[DIMS*DIV_BITS-1:0]),
    .merged_dir_i(mdir_q),
    .split_i     (split_q),
    .count_i     (count_fix),
    .slot_o      (slot),
    .off_node_o  (off_node)
  );

  assign m_axis_tvalid = vld_q[LAT-1];
  assign m_axis_tuser  = off_node;
  if (OUT_PAD > 0) begin : g_pad
    assign m_axis_tdata = {{OUT_PAD{1'b0}}, slot};
  end else begin : g_nopad
    assign m_axis_tdata = slot;
  end

endmodule

// ===== test/tb_lattice_site_index.sv =====
// ---------------------------------------------------------------------------
// tb_lattice_site_index
// Stream testbench for the lattice site index block. A local predictor
// works out the slot and off-node flag of each coordinate that is accepted.
// Every returned transfer is compared in order. The run goes through the
// default box, directed corner cases and random boxes under idle patterns.
// It also covers a long receiver stall and a sender pause until drained.
// ---------------------------------------------------------------------------
module tb_lattice_site_index import lsi_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0] slot;
    logic        off;
  } site_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic [63:0] s_axis_tdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [CFG_ADDR_BITS-1:0] cfg_addr_i = '0;
  logic [CFG_BITS-1:0]      cfg_wdata_i = '0;

  // local copy of the box configuration
  logic [63:0] box_origin = ORIGIN_RST;
  logic [63:0] box_extent = EXTENT_RST;
  logic [15:0] box_divs   = DIVS_RST;
  logic [1:0]  box_mdir   = MDIR_RST;
  logic [8:0]  box_count  = COUNT_RST;
  logic [31:0] box_even   = EVEN_RST;
  logic        box_split  = SPLIT_RST;

  site_res_t slot_q[$];
  int errors = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int stall_req = 0;
  int stall_left = 0;

  lattice_site_index i_dut (
    .clk_i, .rst_ni,
    .s_axis_tdata, .s_axis_tvalid, .s_axis_tready,
    .m_axis_tdata, .m_axis_tuser, .m_axis_tvalid, .m_axis_tready,
    .cfg_we_i, .cfg_addr_i, .cfg_wdata_i
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #3ms;
    $display("FAIL lattice_site_index");
    $finish;
  end

  function automatic logic [31:0] div_count(input int d);
    logic [3:0] v;
    v = box_divs[4*d +: 4];
    return (v == 4'd0) ? 32'd1 : {28'd0, v};
  endfunction

  // slot of one coordinate in the current box
  function automatic site_res_t site_slot(input logic [63:0] w);
    site_res_t r;
    logic [31:0] sub[4];
    logic [31:0] offs[4];
    logic [31:0] psum, ext, ss, q, lbl, idx, cnt;
    int o;
    psum = 0;
    for (int d = 0; d < 4; d++) begin
      ext = {16'd0, box_extent[16*d +: 16]};
      o = int'(w[16*d +: 16]) - int'(box_origin[16*d +: 16]);
      psum += {16'd0, w[16*d +: 16]};
      if (o < 0 || o >= int'(ext)) begin
        r.slot = '0;
        r.off = 1'b1;
        return r;
      end
      offs[d] = o;
      ss = ext / div_count(d);
      sub[d] = (ss == 0) ? 32'd1 : ss;
    end
    cnt = (box_count == 0) ? 32'd1 : {23'd0, box_count};
    // interleaved label of the merged direction
    q = offs[box_mdir] / sub[box_mdir];
    lbl = q / 2 + (q % 2) * (div_count(box_mdir) / 2);
    idx = 0;
    for (int d = 3; d >= 0; d--) begin
      if (d != box_mdir) lbl = lbl * div_count(d) + offs[d] / sub[d];
      idx = idx * sub[d] + offs[d] % sub[d];
    end
    // even sites first, odd sites after them
    if (box_split) begin
      if (psum[0] == 1'b0) idx = idx / 2;
      else idx = idx / 2 + box_even / cnt;
    end
    r.slot = lbl + cnt * idx;
    r.off = 1'b0;
    return r;
  endfunction

  // one transfer on the input stream, expectation stored on acceptance
  task automatic send_coord(input logic [63:0] w);
    int gap;
    gap = ($urandom_range(0, 99) < tx_idle_pct) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= w;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    slot_q = {slot_q, site_slot(w)};
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (slot_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic cfg_write(input cfg_reg_e r, input logic [63:0] v);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= r;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (r)
      REG_ORIGIN: box_origin = v;
      REG_EXTENT: box_extent = v;
      REG_DIVS:   box_divs = v[15:0];
      REG_MDIR:   box_mdir = v[1:0];
      REG_COUNT:  box_count = v[8:0];
      REG_EVEN:   box_even = v[31:0];
      REG_SPLIT:  box_split = v[0];
      default: ;
    endcase
  endtask

  function automatic logic [63:0] coord4(input logic [15:0] x, y, z, t);
    return {t, z, y, x};
  endfunction

  // mostly inside the box, the rest anywhere
  function automatic logic [63:0] rand_coord();
    logic [63:0] w;
    logic [15:0] ext;
    w = {$urandom, $urandom};
    if ($urandom_range(0, 99) < 80) begin
      for (int d = 0; d < 4; d++) begin
        ext = box_extent[16*d +: 16];
        if (ext != 0)
          w[16*d +: 16] = box_origin[16*d +: 16] + 16'($urandom_range(0, ext - 1));
      end
    end
    return w;
  endfunction

  function automatic logic [63:0] rand_extents();
    logic [63:0] e;
    for (int d = 0; d < 4; d++) begin
      case ($urandom_range(0, 9))
        0:       e[16*d +: 16] = 16'($urandom);
        1:       e[16*d +: 16] = 16'd0;
        default: e[16*d +: 16] = 16'($urandom_range(1, 16));
      endcase
    end
    return e;
  endfunction

  // results: compare, then pick the ready for the next cycle
  always @(posedge clk_i or negedge rst_ni) begin
    site_res_t e;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (slot_q.size() == 0) begin
          $display("%0t: unexpected transfer slot %h off %b", $time, m_axis_tdata,
                   m_axis_tuser);
          errors++;
        end else begin
          e = slot_q.pop_front();
          if (m_axis_tdata !== e.slot) begin
            $display("%0t: site_slot expected %h actual %h", $time, e.slot, m_axis_tdata);
            errors++;
          end
          if (m_axis_tuser !== e.off) begin
            $display("%0t: off_node expected %b actual %b", $time, e.off, m_axis_tuser);
            errors++;
          end
        end
      end
      if (stall_req > 0) begin
        stall_left = stall_req;
        stall_req = 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // default box straight after reset
  task automatic test_default_box();
    send_coord(coord4(0, 0, 0, 0));
    send_coord(coord4(1, 0, 0, 0));
    send_coord(coord4(7, 7, 7, 7));
    send_coord(coord4(7, 6, 7, 7));
    send_coord(coord4(8, 0, 0, 0));
    send_coord(coord4(0, 0, 0, 8));
    send_coord(coord4(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_coord(coord4(3, 5, 2, 6));
    drain();
  endtask

  // corner boxes: top origins, zero extent, zero and oversized divisions
  task automatic test_corner_boxes();
    cfg_write(REG_ORIGIN, {4{16'hFFF8}});
    cfg_write(REG_EXTENT, {4{16'd8}});
    cfg_write(REG_DIVS, 16'h2402);
    cfg_write(REG_MDIR, 2'd3);
    cfg_write(REG_COUNT, 9'd16);
    cfg_write(REG_EVEN, 32'hFFFF_FFFF);
    send_coord(coord4(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_coord(coord4(16'hFFF8, 16'hFFF8, 16'hFFF8, 16'hFFF8));
    send_coord(coord4(16'hFFF7, 16'hFFF9, 16'hFFFA, 16'hFFFB));
    send_coord(coord4(16'hFFFD, 16'hFFFA, 16'hFFFF, 16'hFFF9));
    drain();
    // zero counts, divisions above extent, plain order
    cfg_write(REG_EXTENT, {16'd3, 16'd0, 16'd5, 16'd2});
    cfg_write(REG_ORIGIN, 64'd0);
    cfg_write(REG_DIVS, 16'h0F70);
    cfg_write(REG_COUNT, 9'd0);
    cfg_write(REG_SPLIT, 1'b0);
    send_coord(coord4(1, 4, 0, 2));
    drain();
    cfg_write(REG_EXTENT, {16'd3, 16'd4, 16'd5, 16'd2});
    send_coord(coord4(1, 4, 0, 2));
    send_coord(coord4(1, 4, 3, 2));
    send_coord(coord4(0, 0, 0, 0));
    drain();
    cfg_write(REG_SPLIT, 1'b1);
    cfg_write(REG_COUNT, 9'h1FF);
    cfg_write(REG_MDIR, 2'd1);
    cfg_write(REG_EXTENT, {4{16'hFFFF}});
    cfg_write(REG_DIVS, 16'hFFFF);
    send_coord(coord4(16'hFFFE, 16'hFFFE, 16'hFFFE, 16'hFFFE));
    send_coord(coord4(16'h8000, 16'h7FFF, 16'h5555, 16'hAAAA));
    send_coord(coord4(16'hFFFF, 0, 0, 0));
    drain();
  endtask

  // random boxes and coordinates under one idle pattern
  task automatic test_random_boxes(input int boxes, input int per_box);
    for (int b = 0; b < boxes; b++) begin
      cfg_write(REG_ORIGIN, {$urandom, $urandom});
      cfg_write(REG_EXTENT, rand_extents());
      cfg_write(REG_DIVS, 16'($urandom));
      cfg_write(REG_MDIR, 2'($urandom));
      cfg_write(REG_COUNT, 9'($urandom));
      cfg_write(REG_EVEN, $urandom);
      cfg_write(REG_SPLIT, 1'($urandom));
      repeat (per_box) send_coord(rand_coord());
      drain();
    end
  endtask

  // receiver holds off while coordinates keep coming, then a sender pause
  task automatic test_back_pressure();
    @(negedge clk_i);
    stall_req = 300;
    @(posedge clk_i);
    repeat (120) send_coord(rand_coord());
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (slot_q.size() != 0) @(posedge clk_i);
    repeat (60) send_coord(rand_coord());
    drain();
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    tx_idle_pct = 22;
    rx_idle_pct = 61;
    test_default_box();
    test_corner_boxes();
    test_random_boxes(3, 200);
    tx_idle_pct = 61;
    rx_idle_pct = 22;
    test_random_boxes(3, 200);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_boxes(3, 200);
    test_back_pressure();
    if (errors == 0) begin
      $display("PASS lattice_site_index");
    end else begin
      $display("FAIL lattice_site_index");
    end
    $finish;
  end

endmodule
